[rtl/bst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    localparam int NUMBER_BITS = 31;

    localparam logic [3:0] KIND_NUMBER = 4'd0;
    localparam logic [3:0] KIND_IDENT  = 4'd1;
    localparam logic [3:0] KIND_STRING = 4'd2;
    localparam logic [3:0] KIND_COLON  = 4'd3;
    localparam logic [3:0] KIND_LPAREN = 4'd4;
    localparam logic [3:0] KIND_RPAREN = 4'd5;
    localparam logic [3:0] KIND_LBRACE = 4'd6;
    localparam logic [3:0] KIND_RBRACE = 4'd7;
    localparam logic [3:0] KIND_COMMA  = 4'd8;
    localparam logic [3:0] KIND_BTICK  = 4'd9;
    localparam logic [3:0] KIND_DOT    = 4'd10;
    localparam logic [3:0] KIND_ARROW  = 4'd11;
    localparam logic [3:0] KIND_EOS    = 4'd12;
    localparam logic [3:0] KIND_ERROR  = 4'd13;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PRINT_LO = 8'd33;
    localparam logic [7:0] CH_PRINT_HI = 8'd126;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } bst_in_t;

    typedef struct packed {
        logic [3:0]             kind;
        logic [7:0]             text_byte;
        logic                   has_text;
        logic                   token_end;
        logic [NUMBER_BITS-1:0] number_value;
        logic [1:0]             error_code;
        logic                   last;
    } bst_out_t;

    typedef struct packed {
        logic [1:0]     cnt;
        bst_out_t [2:0] data;
    } bst_push_t;

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_punct(logic [7:0] b);
        return (b == CH_COLON) || (b == CH_LPAREN) || (b == CH_RPAREN) ||
               (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_COMMA) ||
               (b == CH_BTICK) || (b == CH_DOT);
    endfunction

    function automatic logic [3:0] punct_kind(logic [7:0] b);
        logic [3:0] k;
        unique case (b)
            CH_COLON:  k = KIND_COLON;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COMMA:  k = KIND_COMMA;
            CH_BTICK:  k = KIND_BTICK;
            CH_DOT:    k = KIND_DOT;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic is_ident_byte(logic [7:0] b);
        return (b >= CH_PRINT_LO) && (b <= CH_PRINT_HI) && !is_punct(b);
    endfunction

    function automatic bst_out_t mk_res(logic [3:0] kind, logic [7:0] text,
                                        logic has_text, logic token_end,
                                        logic [NUMBER_BITS-1:0] num, logic [1:0] err);
        bst_out_t r;
        r.kind         = kind;
        r.text_byte    = text;
        r.has_text     = has_text;
        r.token_end    = token_end;
        r.number_value = num;
        r.error_code   = err;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/bst_lexer.sv]
`timescale 1ns / 1ps
`default_nettype none

module bst_lexer
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bst_pkg::bst_in_t in_data,
    input  wire logic           room,
    output bst_pkg::bst_push_t  push
);
    import bst_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_STRING = 2'd2,
        MODE_IDENT  = 2'd3
    } mode_t;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;
    localparam int WIDE = NUMBER_BITS + 4;

    logic                   vld_reg;
    bst_in_t                item_reg;
    mode_t                  mode_reg, mode_next;
    logic [7:0]             quote_reg, quote_next;
    logic [7:0]             prev_reg, prev_next;
    logic [NUMBER_BITS-1:0] accum_reg, accum_next;
    logic [1:0]             held_reg, held_next;

    logic                   proc;
    logic                   do_close;
    logic                   do_start;
    logic [7:0]             b;
    logic [WIDE-1:0]        acc_wide;
    logic [WIDE-1:0]        acc_scaled;
    bst_out_t [2:0]         res;
    logic [1:0]             n;

    assign proc     = vld_reg && room;
    assign in_ready = !vld_reg || proc;
    assign b        = item_reg.in_byte;

    assign acc_wide   = {4'b0000, accum_reg};
    assign acc_scaled = (acc_wide << 3) + (acc_wide << 1) + WIDE'(b - CH_ZERO);

    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        prev_next  = prev_reg;
        accum_next = accum_reg;
        held_next  = held_reg;
        res        = '0;
        n          = 2'd0;
        do_close   = 1'b0;
        do_start   = 1'b0;

        if (item_reg.end_of_input)
        begin
            do_close = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_NUMBER:
                begin
                    if (is_digit(b))
                    begin
                        if (acc_scaled > WIDE'(NUM_MAX))
                            accum_next = NUM_MAX;
                        else
                            accum_next = acc_scaled[NUMBER_BITS-1:0];
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (b == quote_reg && prev_reg != CH_BSLASH)
                    begin
                        res[n]    = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
                        n         = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res[n]    = mk_res(KIND_STRING, b, 1'b1, 1'b0, '0, ERR_NONE);
                        n         = n + 2'd1;
                        prev_next = b;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_ident_byte(b))
                    begin
                        if (held_reg == 2'd1 && b == CH_GT)
                        begin
                            held_next = 2'd2;
                        end
                        else
                        begin
                            if (held_reg != 2'd0)
                            begin
                                res[n] = mk_res(KIND_IDENT, CH_MINUS, 1'b1, 1'b0, '0,
                                                ERR_NONE);
                                n      = n + 2'd1;
                            end
                            if (held_reg == 2'd2)
                            begin
                                res[n] = mk_res(KIND_IDENT, CH_GT, 1'b1, 1'b0, '0,
                                                ERR_NONE);
                                n      = n + 2'd1;
                            end
                            held_next = 2'd0;
                            res[n]    = mk_res(KIND_IDENT, b, 1'b1, 1'b0, '0, ERR_NONE);
                            n         = n + 2'd1;
                        end
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase
        end

        if (do_close)
        begin
            unique case (mode_reg)
                MODE_NUMBER:
                begin
                    res[n] = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b1, accum_reg, ERR_NONE);
                    n      = n + 2'd1;
                end
                MODE_IDENT:
                begin
                    if (held_reg == 2'd2)
                        res[n] = mk_res(KIND_ARROW, 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
                    else if (held_reg == 2'd1)
                        res[n] = mk_res(KIND_IDENT, CH_MINUS, 1'b1, 1'b1, '0, ERR_NONE);
                    else
                        res[n] = mk_res(KIND_IDENT, 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
                    n = n + 2'd1;
                end
                MODE_STRING:
                begin
                    res[n] = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b1, '0, ERR_UNTERM_STR);
                    n      = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next  = MODE_IDLE;
            held_next  = 2'd0;
            accum_next = '0;
        end

        if (do_start)
        begin
            priority if (is_space(b))
            begin
            end
            else if (is_digit(b))
            begin
                mode_next  = MODE_NUMBER;
                accum_next = NUMBER_BITS'(b - CH_ZERO);
            end
            else if (b == CH_SQUOTE || b == CH_DQUOTE)
            begin
                mode_next  = MODE_STRING;
                quote_next = b;
                prev_next  = b;
            end
            else if (is_ident_byte(b))
            begin
                mode_next = MODE_IDENT;
                if (b == CH_MINUS)
                begin
                    held_next = 2'd1;
                end
                else
                begin
                    held_next = 2'd0;
                    res[n]    = mk_res(KIND_IDENT, b, 1'b1, 1'b0, '0, ERR_NONE);
                    n         = n + 2'd1;
                end
            end
            else if (is_punct(b))
            begin
                res[n] = mk_res(punct_kind(b), 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
                n      = n + 2'd1;
            end
            else
            begin
                res[n] = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b1, '0, ERR_UNEXPECTED);
                n      = n + 2'd1;
            end
        end

        if (item_reg.end_of_input)
        begin
            res[n]     = mk_res(KIND_EOS, 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
            n          = n + 2'd1;
            mode_next  = MODE_IDLE;
            quote_next = 8'h00;
            prev_next  = 8'h00;
            accum_next = '0;
            held_next  = 2'd0;
        end

        if (n != 2'd0)
            res[n - 2'd1].last = 1'b1;

        push.cnt  = proc ? n : 2'd0;
        push.data = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            mode_reg  <= MODE_IDLE;
            quote_reg <= 8'h00;
            prev_reg  <= 8'h00;
            accum_reg <= '0;
            held_reg  <= 2'd0;
        end
        else
        begin
            if (in_ready)
                vld_reg <= in_valid;
            if (proc)
            begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
                prev_reg  <= prev_next;
                accum_reg <= accum_next;
                held_reg  <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_data;
    end

endmodule

`default_nettype wire

[rtl/bst_res_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bst_res_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bst_pkg::bst_push_t push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bst_pkg::bst_out_t      out_data
);
    import bst_pkg::*;

    localparam int DEPTH = 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    bst_out_t        mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = count_reg <= CW'(DEPTH - 3);
    assign count_next = count_reg + CW'(push.cnt) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push.cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < push.cnt)
                mem[wr_ptr_reg + AW'(i)] <= push.data[i];
        end
    end

endmodule

`default_nettype wire

[rtl/byte_stream_tokenizer_core.sv]
// A byte taken at the input is registered in the lexer, lexed once the queue has
// room, and its results are written into the result queue, which offers them.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_ready accepts each result; an eight-entry result queue buffers results.
// Reset: rst_n clears the lexer state and empties the queue at once.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_tokenizer_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bst_pkg::bst_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output bst_pkg::bst_out_t     out_data
);
    import bst_pkg::*;

    bst_push_t push;
    logic      room;

    bst_lexer u_lexer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .room     (room),
        .push     (push)
    );

    bst_res_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[tb/sv/tb_byte_stream_tokenizer_core.sv]
`timescale 1ns / 1ps

module tb_byte_stream_tokenizer_core;

    import bst_pkg::*;

    typedef enum logic [1:0] {LEX_IDLE, LEX_NUMBER, LEX_STRING, LEX_WORD} lex_mode_t;

    localparam longint unsigned NUM_SAT = (64'd1 << NUMBER_BITS) - 64'd1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    bst_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    bst_out_t out_data;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int tokens_checked = 0;

    // predicted lexer state
    lex_mode_t              lex_mode = LEX_IDLE;
    logic [7:0]             quote_byte = 8'h00;
    logic [7:0]             last_str_byte = 8'h00;
    logic [NUMBER_BITS-1:0] num_acc = '0;
    logic [7:0]             word_hold [2] = '{8'h00, 8'h00};
    int unsigned            dash_count = 0;

    bst_out_t tokens_due [$];
    bst_out_t step_tokens [$];

    byte_stream_tokenizer_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic bit is_decimal(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic [3:0] punct_token(logic [7:0] b);
        case (b)
            CH_COLON:  return KIND_COLON;
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            CH_LBRACE: return KIND_LBRACE;
            CH_RBRACE: return KIND_RBRACE;
            CH_COMMA:  return KIND_COMMA;
            CH_BTICK:  return KIND_BTICK;
            CH_DOT:    return KIND_DOT;
            default:   return KIND_ERROR;
        endcase
    endfunction

    function automatic bit is_word(logic [7:0] b);
        return b >= CH_PRINT_LO && b <= CH_PRINT_HI && punct_token(b) == KIND_ERROR;
    endfunction

    function automatic void push_token(logic [3:0] kind, logic [7:0] text, bit has_text,
                                       bit closes, logic [NUMBER_BITS-1:0] value,
                                       logic [1:0] err);
        bst_out_t t;
        t.kind         = kind;
        t.text_byte    = text;
        t.has_text     = has_text;
        t.token_end    = closes;
        t.number_value = value;
        t.error_code   = err;
        t.last         = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void flush_pending();
        case (lex_mode)
            LEX_NUMBER: push_token(KIND_NUMBER, 8'h00, 1'b0, 1'b1, num_acc, ERR_NONE);
            LEX_WORD:
            begin
                if (dash_count == 2)
                    push_token(KIND_ARROW, 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
                else if (dash_count == 1)
                    push_token(KIND_IDENT, word_hold[0], 1'b1, 1'b1, '0, ERR_NONE);
                else
                    push_token(KIND_IDENT, 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
            end
            LEX_STRING: push_token(KIND_ERROR, 8'h00, 1'b0, 1'b1, '0, ERR_UNTERM_STR);
            default: ;
        endcase
        lex_mode   = LEX_IDLE;
        dash_count = 0;
        num_acc    = '0;
    endfunction

    function automatic void begin_token(logic [7:0] b);
        if (is_blank(b))
        begin
        end
        else if (is_decimal(b))
        begin
            lex_mode = LEX_NUMBER;
            num_acc  = NUMBER_BITS'(b - CH_ZERO);
        end
        else if (b == CH_SQUOTE || b == CH_DQUOTE)
        begin
            lex_mode      = LEX_STRING;
            quote_byte    = b;
            last_str_byte = b;
        end
        else if (is_word(b))
        begin
            lex_mode = LEX_WORD;
            if (b == CH_MINUS)
            begin
                word_hold[0] = b;
                dash_count   = 1;
            end
            else
            begin
                dash_count = 0;
                push_token(KIND_IDENT, b, 1'b1, 1'b0, '0, ERR_NONE);
            end
        end
        else if (punct_token(b) != KIND_ERROR)
            push_token(punct_token(b), 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
        else
            push_token(KIND_ERROR, 8'h00, 1'b0, 1'b1, '0, ERR_UNEXPECTED);
    endfunction

    function automatic void extend_word(logic [7:0] b);
        if (dash_count == 1 && b == CH_GT)
        begin
            word_hold[1] = b;
            dash_count   = 2;
        end
        else
        begin
            if (dash_count >= 1)
                push_token(KIND_IDENT, word_hold[0], 1'b1, 1'b0, '0, ERR_NONE);
            if (dash_count == 2)
                push_token(KIND_IDENT, word_hold[1], 1'b1, 1'b0, '0, ERR_NONE);
            dash_count = 0;
            push_token(KIND_IDENT, b, 1'b1, 1'b0, '0, ERR_NONE);
        end
    endfunction

    function automatic void lex_byte(bst_in_t item);
        logic [7:0]      b;
        longint unsigned digit;
        b = item.in_byte;
        step_tokens.delete();
        if (item.end_of_input)
        begin
            flush_pending();
            push_token(KIND_EOS, 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
            quote_byte    = 8'h00;
            last_str_byte = 8'h00;
            word_hold     = '{8'h00, 8'h00};
        end
        else if (lex_mode == LEX_NUMBER && is_decimal(b))
        begin
            digit = 64'(b - CH_ZERO);
            if (num_acc > (NUM_SAT - digit) / 10)
                num_acc = NUMBER_BITS'(NUM_SAT);
            else
                num_acc = NUMBER_BITS'(num_acc * 10 + digit);
        end
        else if (lex_mode == LEX_STRING)
        begin
            if (b == quote_byte && last_str_byte != CH_BSLASH)
            begin
                push_token(KIND_STRING, 8'h00, 1'b0, 1'b1, '0, ERR_NONE);
                lex_mode = LEX_IDLE;
            end
            else
            begin
                push_token(KIND_STRING, b, 1'b1, 1'b0, '0, ERR_NONE);
                last_str_byte = b;
            end
        end
        else if (lex_mode == LEX_WORD && is_word(b))
            extend_word(b);
        else
        begin
            flush_pending();
            begin_token(b);
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            tokens_due.push_back(step_tokens[i]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        bst_in_t item;
        item.in_byte      = b;
        item.end_of_input = eoi;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        lex_byte(item);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] word_start();
        logic [7:0] b;
        do
            b = 8'($urandom_range(126, 33));
        while (!is_word(b) || is_decimal(b) || b == CH_MINUS ||
               b == CH_SQUOTE || b == CH_DQUOTE);
        return b;
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        case ($urandom_range(7))
            0:       b = CH_MINUS;
            1:       b = CH_GT;
            default:
            begin
                do
                    b = 8'($urandom_range(126, 33));
                while (!is_word(b));
            end
        endcase
        return b;
    endfunction

    function automatic logic [7:0] string_byte(logic [7:0] q);
        case ($urandom_range(9))
            0, 1:    return CH_BSLASH;
            2:       return q;
            3, 4, 5: return 8'($urandom_range(126, 32));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_punctuation();
        send_text(":(){},`.");
    endtask

    // arrow, then a lone minus closed by a colon
    task automatic test_arrow_and_minus();
        send_text("-> -:");
    endtask

    task automatic test_escaped_quote();
        send_text("'\\''");
    endtask

    task automatic test_unexpected_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // number closed by a minus, identifier closed by end, then an open string at end
    task automatic test_end_of_stream();
        send_text("7-x");
        send_byte(8'($urandom_range(255)), 1'b1);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic test_random_streams(input int count);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] q;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                len = ($urandom_range(3) == 0) ? $urandom_range(12, 8) : $urandom_range(4, 1);
                repeat (len)
                    send_byte(8'(CH_ZERO + $urandom_range(9)), 1'b0);
            end
            else if (pick < 36)
            begin
                send_byte(word_start(), 1'b0);
                repeat ($urandom_range(5))
                    send_byte(word_byte(), 1'b0);
            end
            else if (pick < 45)
            begin
                send_byte(CH_MINUS, 1'b0);
                if ($urandom_range(3) != 0)
                    send_byte(CH_GT, 1'b0);
                if ($urandom_range(1) != 0)
                    send_byte(word_byte(), 1'b0);
            end
            else if (pick < 63)
            begin
                q = ($urandom_range(1) != 0) ? CH_SQUOTE : CH_DQUOTE;
                send_byte(q, 1'b0);
                repeat ($urandom_range(6))
                    send_byte(string_byte(q), 1'b0);
                if ($urandom_range(9) == 0)
                    send_byte(8'($urandom_range(255)), 1'b1);
                else
                    send_byte(q, 1'b0);
            end
            else if (pick < 76)
            begin
                case ($urandom_range(7))
                    0:       send_byte(CH_COLON, 1'b0);
                    1:       send_byte(CH_LPAREN, 1'b0);
                    2:       send_byte(CH_RPAREN, 1'b0);
                    3:       send_byte(CH_LBRACE, 1'b0);
                    4:       send_byte(CH_RBRACE, 1'b0);
                    5:       send_byte(CH_COMMA, 1'b0);
                    6:       send_byte(CH_BTICK, 1'b0);
                    default: send_byte(CH_DOT, 1'b0);
                endcase
            end
            else if (pick < 88)
            begin
                case ($urandom_range(3))
                    0:       send_byte(CH_TAB, 1'b0);
                    1:       send_byte(CH_LF, 1'b0);
                    2:       send_byte(CH_CR, 1'b0);
                    default: send_byte(CH_SPACE, 1'b0);
                endcase
            end
            else if (pick < 95)
                send_byte(8'($urandom_range(255)), 1'b0);
            else
                send_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        bst_out_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("token result with none expected: kind %0d", out_data.kind);
                error_count++;
            end
            else
            begin
                want = tokens_due.pop_front();
                tokens_checked++;
                check_field("kind", 64'(want.kind), 64'(out_data.kind));
                check_field("text_byte", 64'(want.text_byte), 64'(out_data.text_byte));
                check_field("has_text", 64'(want.has_text), 64'(out_data.has_text));
                check_field("token_end", 64'(want.token_end), 64'(out_data.token_end));
                check_field("number_value", 64'(want.number_value),
                            64'(out_data.number_value));
                check_field("error_code", 64'(want.error_code), 64'(out_data.error_code));
                check_field("last", 64'(want.last), 64'(out_data.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timed out with %0d results outstanding", tokens_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 16;
        recv_stall_pct = 50;
        test_punctuation();
        test_arrow_and_minus();
        test_escaped_quote();
        test_unexpected_bytes();
        test_end_of_stream();
        test_random_streams(140);

        send_gap_pct   = 50;
        recv_stall_pct = 16;
        test_random_streams(140);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_streams(140);

        in_valid <= 1'b0;
        wait (tokens_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered punctuation, saturating numbers, identifiers and arrows, escaped strings,");
        $display("bad bytes and end of stream: %0d requests sent, %0d results checked.",
                 bytes_sent, tokens_checked);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[byte_stream_tokenizer_core.f]
rtl/bst_pkg.sv
rtl/bst_lexer.sv
rtl/bst_res_queue.sv
rtl/byte_stream_tokenizer_core.sv
tb/sv/tb_byte_stream_tokenizer_core.sv
